// ===== rtl/core/idc_pkg.sv =====
// Shared types and constants for the interrupt dispatch controller.
package idc_pkg;

	localparam int unsigned NumSourcesDefault = 5;
	localparam int unsigned SrcWidth = 5;

	localparam logic [1:0] MODE_RUN      = 2'd0;
	localparam logic [1:0] MODE_DISPATCH = 2'd2;
	localparam logic [1:0] MODE_UNKNOWN  = 2'd3;

	localparam logic OP_UPDATE   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [2:0] STEP_CLEAR_ME = 3'd0;
	localparam logic [2:0] STEP_IDLE     = 3'd1;
	localparam logic [2:0] STEP_PUSH_HI  = 3'd2;
	localparam logic [2:0] STEP_PUSH_LO  = 3'd3;
	localparam logic [2:0] STEP_VECTOR   = 3'd4;

	localparam logic [SrcWidth-1:0] STATUS_BIT = 5'b00010;
	localparam logic [15:0] VECTOR_BASE = 16'h0040;

	typedef struct packed {
		logic                opcode;
		logic [SrcWidth-1:0] enable_bits;
		logic [SrcWidth-1:0] request_bits;
		logic                status_line;
		logic [1:0]          mode_in;
		logic                enable_request;
		logic [15:0]         program_counter;
		logic [15:0]         stack_pointer;
	} cycle_t;

	typedef struct packed {
		logic [1:0]          mode_out;
		logic [2:0]          step_out;
		logic [SrcWidth-1:0] request_set_mask;
		logic [SrcWidth-1:0] request_clear_mask;
		logic                write_valid;
		logic [15:0]         write_address;
		logic [7:0]          write_data;
		logic                pc_write;
		logic [15:0]         new_pc;
		logic [15:0]         new_sp;
		logic                master_enable_out;
	} action_t;

endpackage

// ===== rtl/core/idc_stream_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
interface idc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/interrupt_dispatch_controller.sv =====
// Interrupt dispatch controller: per-cycle update and five-step dispatch sequencer.
// Each cycle transaction is registered on input, evaluated against the controller
// state in one pass and written to an output register, so one transaction is taken
// every clock while the sink keeps up; an action held by a stalled sink stops intake only
// once the input register is also full. The controller state (step counter, master
// enable, delayed enable, status line history and latched pending set) advances
// once per transaction in acceptance order.
module interrupt_dispatch_controller #(
	parameter int unsigned NUM_SOURCES = idc_pkg::NumSourcesDefault
) (
	input logic clk,
	input logic arst_n,
	idc_stream_if.sink   cycle,
	idc_stream_if.source action
);
	import idc_pkg::*;

	localparam logic [SrcWidth-1:0] SrcMask =
		SrcWidth'(((1 << NUM_SOURCES) - 1) & ((1 << SrcWidth) - 1));

	cycle_t  cyc_s1;
	logic    valid_s1;
	action_t act_q;
	logic    act_valid_q;
	action_t act_d;
	logic    advance;

	logic [2:0]          step_q, step_d;
	logic                me_q, me_d;
	logic                ep_q, ep_d;
	logic                line_last_q, line_last_d;
	logic [SrcWidth-1:0] latched_q, latched_d;

	logic [1:0]          mode;
	logic [SrcWidth-1:0] req_eff;
	logic                hit;
	logic                blocked;
	logic                sched;
	logic [15:0]         sp_dec;

	assign advance      = valid_s1 && (!act_valid_q || action.ready);
	assign cycle.ready  = !valid_s1 || advance;
	assign action.valid = act_valid_q;
	assign action.data  = act_q;
	assign sp_dec       = cyc_s1.stack_pointer - 16'd1;

	always_comb begin
		step_d      = step_q;
		me_d        = me_q;
		ep_d        = ep_q;
		line_last_d = line_last_q;
		latched_d   = latched_q;
		mode        = (cyc_s1.mode_in == MODE_UNKNOWN) ? MODE_RUN : cyc_s1.mode_in;
		req_eff     = cyc_s1.request_bits;
		hit         = 1'b0;
		blocked     = 1'b0;
		sched       = 1'b0;
		act_d       = '0;
		act_d.new_pc = cyc_s1.program_counter;
		act_d.new_sp = cyc_s1.stack_pointer;
		if (cyc_s1.opcode == OP_UPDATE) begin
			sched = ep_q | cyc_s1.enable_request;
			ep_d  = 1'b0;
			if (cyc_s1.status_line && !line_last_q) begin
				act_d.request_set_mask = STATUS_BIT;
				req_eff = cyc_s1.request_bits | STATUS_BIT;
			end
			line_last_d = cyc_s1.status_line;
			hit = |(cyc_s1.enable_bits & req_eff & SrcMask);
			if (hit) begin
				mode = MODE_RUN;
			end
			blocked = sched && !me_q;
			if (blocked) begin
				me_d = 1'b1;
			end
			if (!blocked && me_q && hit) begin
				mode = MODE_DISPATCH;
			end
		end else begin
			if (cyc_s1.enable_request) begin
				ep_d = 1'b1;
			end
			case (step_q)
				STEP_CLEAR_ME: begin
					step_d = STEP_IDLE;
					me_d   = 1'b0;
				end
				STEP_IDLE: begin
					step_d = STEP_PUSH_HI;
				end
				STEP_PUSH_HI: begin
					step_d              = STEP_PUSH_LO;
					act_d.new_sp        = sp_dec;
					act_d.write_valid   = 1'b1;
					act_d.write_address = sp_dec;
					act_d.write_data    = cyc_s1.program_counter[15:8];
				end
				STEP_PUSH_LO: begin
					step_d              = STEP_VECTOR;
					latched_d           = cyc_s1.enable_bits & cyc_s1.request_bits & SrcMask;
					act_d.new_sp        = sp_dec;
					act_d.write_valid   = 1'b1;
					act_d.write_address = sp_dec;
					act_d.write_data    = cyc_s1.program_counter[7:0];
				end
				STEP_VECTOR: begin
					step_d         = STEP_CLEAR_ME;
					mode           = MODE_RUN;
					act_d.pc_write = 1'b1;
					act_d.new_pc   = '0;
					for (int i = SrcWidth - 1; i >= 0; i--) begin
						if (latched_q[i]) begin
							act_d.request_clear_mask = SrcWidth'(1 << i);
							act_d.new_pc = VECTOR_BASE + 16'(i << 3);
						end
					end
				end
				default: begin
					step_d = STEP_CLEAR_ME;
				end
			endcase
		end
		act_d.mode_out          = mode;
		act_d.step_out          = step_d;
		act_d.master_enable_out = me_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			act_valid_q <= 1'b0;
			step_q      <= STEP_CLEAR_ME;
			me_q        <= 1'b0;
			ep_q        <= 1'b0;
			line_last_q <= 1'b0;
			latched_q   <= '0;
		end else begin
			if (cycle.ready) begin
				valid_s1 <= cycle.valid;
			end
			if (advance) begin
				act_valid_q <= 1'b1;
				step_q      <= step_d;
				me_q        <= me_d;
				ep_q        <= ep_d;
				line_last_q <= line_last_d;
				latched_q   <= latched_d;
			end else if (action.ready) begin
				act_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cycle.valid && cycle.ready) begin
			cyc_s1 <= cycle.data;
		end
		if (advance) begin
			act_q <= act_d;
		end
	end

	a_push_steps: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q && act_q.write_valid |->
			(act_q.step_out == STEP_PUSH_LO || act_q.step_out == STEP_VECTOR))
		else $error("stack push outside the push steps");

	a_vector_ends: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q && act_q.pc_write |->
			(act_q.step_out == STEP_CLEAR_ME && act_q.mode_out == MODE_RUN))
		else $error("vector issued without ending the sequence");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && act_valid_q && !action.ready |-> !cycle.ready)
		else $error("intake open while both registers are full");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> act_valid_q)
		else $error("evaluated transaction did not reach the output register");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the interrupt dispatch controller.
module tb;
	import idc_pkg::*;

	localparam logic [1:0] MODE_HALT = 2'd1;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned RANDOM_ITEMS = 400;

	class dispatch_scoreboard;
		action_t expected_q[$];
		int unsigned mismatches;
		logic [2:0] step;
		logic ime;
		logic ime_held;
		logic line_last;
		logic [SrcWidth-1:0] latched;

		function new();
			step = STEP_CLEAR_ME;
			ime = 1'b0;
			ime_held = 1'b0;
			line_last = 1'b0;
			latched = '0;
			mismatches = 0;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		function void note_cycle(input cycle_t c);
			action_t a;
			logic [1:0] mode;
			logic [SrcWidth-1:0] req;
			logic sched;
			logic blocked;
			a = '0;
			a.new_pc = c.program_counter;
			a.new_sp = c.stack_pointer;
			mode = (c.mode_in == MODE_UNKNOWN) ? MODE_RUN : c.mode_in;
			req = c.request_bits;
			if (c.opcode == OP_UPDATE) begin
				sched = ime_held | c.enable_request;
				blocked = 1'b0;
				ime_held = 1'b0;
				if (c.status_line && !line_last) begin
					a.request_set_mask = STATUS_BIT;
					req = req | STATUS_BIT;
				end
				line_last = c.status_line;
				if ((c.enable_bits & req) != '0)
					mode = MODE_RUN;
				if (sched && !ime) begin
					ime = 1'b1;
					blocked = 1'b1;
				end
				if (!blocked && ime && (c.enable_bits & req) != '0)
					mode = MODE_DISPATCH;
			end else begin
				if (c.enable_request)
					ime_held = 1'b1;
				case (step)
					STEP_CLEAR_ME: begin
						step = STEP_IDLE;
						ime = 1'b0;
					end
					STEP_IDLE: begin
						step = STEP_PUSH_HI;
					end
					STEP_PUSH_HI: begin
						step = STEP_PUSH_LO;
						a.new_sp = c.stack_pointer - 16'd1;
						a.write_valid = 1'b1;
						a.write_address = a.new_sp;
						a.write_data = c.program_counter[15:8];
					end
					STEP_PUSH_LO: begin
						step = STEP_VECTOR;
						latched = c.enable_bits & req;
						a.new_sp = c.stack_pointer - 16'd1;
						a.write_valid = 1'b1;
						a.write_address = a.new_sp;
						a.write_data = c.program_counter[7:0];
					end
					STEP_VECTOR: begin
						step = STEP_CLEAR_ME;
						mode = MODE_RUN;
						a.pc_write = 1'b1;
						a.new_pc = '0;
						for (int i = SrcWidth - 1; i >= 0; i--) begin
							if (latched[i]) begin
								a.request_clear_mask = '0;
								a.request_clear_mask[i] = 1'b1;
								a.new_pc = VECTOR_BASE + 16'(i * 8);
							end
						end
					end
					default: begin
						step = STEP_CLEAR_ME;
					end
				endcase
			end
			a.mode_out = mode;
			a.step_out = step;
			a.master_enable_out = ime;
			expected_q.push_back(a);
		endfunction

		task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_action(input action_t got);
			action_t want;
			if (expected_q.size() == 0) begin
				report("action transaction with none expected");
			end else begin
				want = expected_q.pop_front();
				compare_field("mode_out", got.mode_out, want.mode_out);
				compare_field("step_out", got.step_out, want.step_out);
				compare_field("request_set_mask", got.request_set_mask,
					want.request_set_mask);
				compare_field("request_clear_mask", got.request_clear_mask,
					want.request_clear_mask);
				compare_field("write_valid", got.write_valid, want.write_valid);
				compare_field("write_address", got.write_address, want.write_address);
				compare_field("write_data", got.write_data, want.write_data);
				compare_field("pc_write", got.pc_write, want.pc_write);
				compare_field("new_pc", got.new_pc, want.new_pc);
				compare_field("new_sp", got.new_sp, want.new_sp);
				compare_field("master_enable_out", got.master_enable_out,
					want.master_enable_out);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	int unsigned sent_count;
	bit src_idle;
	bit snk_idle;
	dispatch_scoreboard sb;

	idc_stream_if #(.payload_t(cycle_t)) cycle_if ();
	idc_stream_if #(.payload_t(action_t)) action_if ();

	interrupt_dispatch_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cycle  (cycle_if),
		.action (action_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic cycle_t make_cycle(input logic op, input logic [4:0] ie,
		input logic [4:0] ir, input logic line, input logic [1:0] mode,
		input logic ereq, input logic [15:0] pc, input logic [15:0] sp);
		cycle_t c;
		c.opcode = op;
		c.enable_bits = ie;
		c.request_bits = ir;
		c.status_line = line;
		c.mode_in = mode;
		c.enable_request = ereq;
		c.program_counter = pc;
		c.stack_pointer = sp;
		return c;
	endfunction

	function automatic cycle_t random_cycle(input logic op, input int unsigned ereq_odds);
		cycle_t c;
		c.opcode = op;
		c.enable_bits = 5'($urandom);
		c.request_bits = 5'($urandom);
		c.status_line = 1'($urandom);
		c.mode_in = 2'($urandom_range(0, 3));
		c.enable_request = ($urandom_range(0, ereq_odds) == 0);
		c.program_counter = 16'($urandom);
		case ($urandom_range(0, 15))
			0: c.stack_pointer = 16'h0000;
			1: c.stack_pointer = 16'h0001;
			2: c.stack_pointer = 16'hFFFF;
			default: c.stack_pointer = 16'($urandom);
		endcase
		return c;
	endfunction

	task automatic send_cycle(input cycle_t c);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			cycle_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cycle_if.valid <= 1'b1;
		cycle_if.data <= c;
		do @(posedge clk); while (!cycle_if.ready);
		sb.note_cycle(c);
		sent_count++;
	endtask

	task automatic drain_actions();
		cycle_if.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int unsigned stall;
			stall = snk_idle ? $urandom_range(0, 3) : 0;
			if (stall != 0) begin
				action_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			action_if.ready <= 1'b1;
			do @(posedge clk); while (!action_if.valid);
			sb.check_action(action_if.data);
		end
	end

	initial begin
		int unsigned kind;
		sb = new();
		sent_count = 0;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		arst_n <= 1'b0;
		cycle_if.valid <= 1'b0;
		cycle_if.data <= '0;
		action_if.ready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Status edge, wake from halt, unknown mode and the blocked first enable.
		send_cycle(make_cycle(OP_UPDATE, 5'h00, 5'h00, 1'b0, MODE_RUN, 1'b0, 16'h0000, 16'h0000));
		send_cycle(make_cycle(OP_UPDATE, 5'h02, 5'h00, 1'b1, MODE_HALT, 1'b0, 16'h1234, 16'hC000));
		send_cycle(make_cycle(OP_UPDATE, 5'h1F, 5'h00, 1'b1, MODE_UNKNOWN, 1'b0, 16'h1234, 16'hC000));
		send_cycle(make_cycle(OP_UPDATE, 5'h1F, 5'h1F, 1'b0, MODE_HALT, 1'b1, 16'h1234, 16'hC000));
		send_cycle(make_cycle(OP_UPDATE, 5'h1F, 5'h01, 1'b0, MODE_RUN, 1'b0, 16'hFFFF, 16'h0000));
		// Full sequence with stack wrap and a held enable request.
		send_cycle(make_cycle(OP_DISPATCH, 5'h10, 5'h18, 1'b0, MODE_DISPATCH, 1'b1, 16'hFFFF, 16'h0000));
		send_cycle(make_cycle(OP_DISPATCH, 5'h10, 5'h18, 1'b0, MODE_DISPATCH, 1'b0, 16'hFFFF, 16'h0000));
		send_cycle(make_cycle(OP_DISPATCH, 5'h10, 5'h18, 1'b0, MODE_DISPATCH, 1'b0, 16'hFFFF, 16'h0000));
		send_cycle(make_cycle(OP_DISPATCH, 5'h10, 5'h18, 1'b0, MODE_DISPATCH, 1'b0, 16'hFFFF, 16'hFFFF));
		send_cycle(make_cycle(OP_DISPATCH, 5'h10, 5'h18, 1'b0, MODE_DISPATCH, 1'b0, 16'hFFFF, 16'hFFFE));
		// Held enable lands while in dispatch mode with master enable clear.
		send_cycle(make_cycle(OP_UPDATE, 5'h01, 5'h01, 1'b0, MODE_DISPATCH, 1'b0, 16'h0060, 16'hFFFE));
		send_cycle(make_cycle(OP_UPDATE, 5'h01, 5'h01, 1'b0, MODE_DISPATCH, 1'b0, 16'h0060, 16'hFFFE));
		// Sequence with an update in the middle and nothing latched.
		send_cycle(make_cycle(OP_DISPATCH, 5'h01, 5'h01, 1'b0, MODE_UNKNOWN, 1'b0, 16'h0000, 16'hFFFF));
		send_cycle(make_cycle(OP_DISPATCH, 5'h01, 5'h01, 1'b0, MODE_DISPATCH, 1'b0, 16'h0000, 16'hFFFF));
		send_cycle(make_cycle(OP_UPDATE, 5'h00, 5'h1F, 1'b1, MODE_DISPATCH, 1'b0, 16'h0000, 16'hFFFF));
		send_cycle(make_cycle(OP_DISPATCH, 5'h00, 5'h1F, 1'b0, MODE_DISPATCH, 1'b0, 16'h0000, 16'hFFFF));
		send_cycle(make_cycle(OP_DISPATCH, 5'h00, 5'h1F, 1'b0, MODE_DISPATCH, 1'b0, 16'h0000, 16'hFFFE));
		send_cycle(make_cycle(OP_DISPATCH, 5'h00, 5'h1F, 1'b0, MODE_DISPATCH, 1'b0, 16'h0000, 16'hFFFD));
		send_cycle(make_cycle(OP_UPDATE, 5'h04, 5'h04, 1'b0, MODE_RUN, 1'b1, 16'hABCD, 16'h8000));
		send_cycle(make_cycle(OP_UPDATE, 5'h04, 5'h04, 1'b0, MODE_RUN, 1'b0, 16'hABCD, 16'h8000));
		drain_actions();

		while (sent_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				src_idle = ~src_idle;
			if ($urandom_range(0, 15) == 0)
				snk_idle = ~snk_idle;
			kind = $urandom_range(0, 19);
			if (kind < 7) begin
				repeat ($urandom_range(1, 3)) send_cycle(random_cycle(OP_UPDATE, 2));
			end else if (kind < 17) begin
				for (int s = 0; s < 5; s++) begin
					if ($urandom_range(0, 5) == 0)
						send_cycle(random_cycle(OP_UPDATE, 3));
					send_cycle(random_cycle(OP_DISPATCH, 5));
				end
			end else if (kind < 19) begin
				send_cycle(random_cycle(OP_DISPATCH, 3));
			end else begin
				drain_actions();
			end
		end

		drain_actions();
		repeat (8) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report("expected actions left at end of run");
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
